// ===== src/sfcd_pkg.sv =====
// Package: payload types, frame constants and the CRC byte update for the frame checker.
`default_nettype none

package sfcd_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  FuncCode = 8'h03;
  localparam logic [7:0]  MagMask  = 8'h7F;
  localparam logic [7:0]  SignBit  = 8'h80;

  // Byte positions within the 8-byte response frame
  localparam logic [2:0] IdxCode    = 3'd0;
  localparam logic [2:0] IdxLen     = 3'd1;
  localparam logic [2:0] IdxHumHi   = 3'd2;
  localparam logic [2:0] IdxHumLo   = 3'd3;
  localparam logic [2:0] IdxTempHi  = 3'd4;
  localparam logic [2:0] IdxTempLo  = 3'd5;
  localparam logic [2:0] IdxCrcLo   = 3'd6;
  localparam logic [2:0] IdxCrcHi   = 3'd7;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusCodeBad = 2'd1,
    StatusCrcBad  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] temperature_tenths;
    logic        [15:0] humidity_tenths;
  } out_item_t;

  // Reflected CRC-16 update over one byte, unrolled over its eight bits.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/sensor_frame_check_decode_core.sv =====
// Top level: byte-serial check and decode of the 8-byte sensor response frame.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one response
//   byte per item, with frame_start marking byte 0 of a frame. Bytes 0-5 are
//   folded into a reflected CRC-16 (poly 0xA001, init 0xFFFF); bytes 2-5 are
//   captured as humidity and temperature words; bytes 6-7 are the received CRC.
//   Without frame_start the byte index just advances and wraps after byte 7.
//   The output channel (out_valid_o / out_stall_i / out_data_o) carries one
//   item per frame: status, signed temperature and humidity in tenths, both
//   zero when status is not OK. A bad function code wins over a bad CRC.
//   Throughput: one byte per cycle outside a stall; the byte-wide CRC update
//   and field capture finish in the cycle the byte is accepted.
//   Latency: the result item is valid the cycle after byte 7 is accepted,
//   held in the output register.
//   Stall: while a result waits under out_stall_i, bytes 0-6 are still taken;
//   only a byte that would complete a frame is stalled.
//   Reset: clears the byte index, captured fields and the output valid, and
//   loads the CRC with its initial value.
`default_nettype none

module sensor_frame_check_decode_core (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  sfcd_pkg::in_item_t      in_data_i,
  output logic                    out_valid_o,
  input  wire                     out_stall_i,
  output sfcd_pkg::out_item_t     out_data_o
);

  logic [2:0]  byte_index_q, byte_index_d;
  logic [15:0] running_crc_q, running_crc_d;
  logic        code_bad_q, code_bad_d;
  logic [15:0] humidity_word_q, humidity_word_d;
  logic [15:0] temperature_word_q, temperature_word_d;
  logic [7:0]  crc_low_byte_q, crc_low_byte_d;
  logic        out_valid_q, out_valid_d;
  sfcd_pkg::out_item_t out_data_q, out_data_d;

  logic [2:0]  idx;
  logic        in_acc;
  logic        last_byte;
  logic [15:0] crc_seed;
  logic [15:0] crc_next;
  logic [15:0] rx_crc;
  logic [14:0] temp_mag;

  // Position of this byte; a frame mark restarts at byte 0
  assign idx       = in_data_i.frame_start ? sfcd_pkg::IdxCode : byte_index_q;
  assign last_byte = (idx == sfcd_pkg::IdxCrcHi);

  // Hold only a frame-completing byte while the result register is blocked
  assign in_stall_o = out_valid_q && out_stall_i && last_byte;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign crc_seed = (idx == sfcd_pkg::IdxCode) ? sfcd_pkg::CrcInit : running_crc_q;
  assign crc_next = sfcd_pkg::crc_byte(crc_seed, in_data_i.rx_byte);
  assign rx_crc   = {in_data_i.rx_byte, crc_low_byte_q};
  assign temp_mag = {temperature_word_q[14:8] & sfcd_pkg::MagMask[6:0],
                     temperature_word_q[7:0]};

  always_comb begin
    byte_index_d       = byte_index_q;
    running_crc_d      = running_crc_q;
    code_bad_d         = code_bad_q;
    humidity_word_d    = humidity_word_q;
    temperature_word_d = temperature_word_q;
    crc_low_byte_d     = crc_low_byte_q;
    out_valid_d        = out_valid_q && out_stall_i;
    out_data_d         = out_data_q;

    if (in_acc) begin
      byte_index_d = idx + 3'd1;
      unique case (idx)
        sfcd_pkg::IdxCode: begin
          code_bad_d    = (in_data_i.rx_byte != sfcd_pkg::FuncCode);
          running_crc_d = crc_next;
        end
        sfcd_pkg::IdxLen: begin
          running_crc_d = crc_next;
        end
        sfcd_pkg::IdxHumHi: begin
          running_crc_d         = crc_next;
          humidity_word_d[15:8] = in_data_i.rx_byte;
        end
        sfcd_pkg::IdxHumLo: begin
          running_crc_d        = crc_next;
          humidity_word_d[7:0] = in_data_i.rx_byte;
        end
        sfcd_pkg::IdxTempHi: begin
          running_crc_d            = crc_next;
          temperature_word_d[15:8] = in_data_i.rx_byte;
        end
        sfcd_pkg::IdxTempLo: begin
          running_crc_d           = crc_next;
          temperature_word_d[7:0] = in_data_i.rx_byte;
        end
        sfcd_pkg::IdxCrcLo: begin
          crc_low_byte_d = in_data_i.rx_byte;
        end
        default: begin
          // Last byte: compare and load the result register
          out_valid_d = 1'b1;
          out_data_d.temperature_tenths = '0;
          out_data_d.humidity_tenths    = '0;
          priority if (code_bad_q) begin
            out_data_d.status = sfcd_pkg::StatusCodeBad;
          end else if (rx_crc != running_crc_q) begin
            out_data_d.status = sfcd_pkg::StatusCrcBad;
          end else begin
            out_data_d.status = sfcd_pkg::StatusOk;
            // Sign-magnitude to two's complement; negative zero comes out as 0
            if ((temperature_word_q[15:8] & sfcd_pkg::SignBit) != 8'h00) begin
              out_data_d.temperature_tenths = 16'sd0 - $signed({1'b0, temp_mag});
            end else begin
              out_data_d.temperature_tenths = $signed({1'b0, temp_mag});
            end
            out_data_d.humidity_tenths = humidity_word_q;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q       <= '0;
      running_crc_q      <= sfcd_pkg::CrcInit;
      code_bad_q         <= 1'b0;
      humidity_word_q    <= '0;
      temperature_word_q <= '0;
      crc_low_byte_q     <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      byte_index_q       <= byte_index_d;
      running_crc_q      <= running_crc_d;
      code_bad_q         <= code_bad_d;
      humidity_word_q    <= humidity_word_d;
      temperature_word_q <= temperature_word_d;
      crc_low_byte_q     <= crc_low_byte_d;
      out_valid_q        <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A new result appears only after the frame-completing byte was taken
  a_result_from_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && last_byte))
    else $error("result appeared without a last byte");

  // Never overwrite a result that is still held by the receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && in_acc) |-> !last_byte)
    else $error("held result overwritten");

  // Error results carry zero readings
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.status != sfcd_pkg::StatusOk) |->
      (out_data_q.temperature_tenths == 16'sd0 && out_data_q.humidity_tenths == 16'd0))
    else $error("nonzero readings on error result");

  // A frame mark restarts the byte index
  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.frame_start) |=> (byte_index_q == 3'd1))
    else $error("frame start did not restart index");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench: byte-serial sensor frame check and decode, checked against a bit-level frame model.
module tb;

  // Where the CRC bytes of a directed row come from: typed in, or taken from the
  // running CRC of the bytes accepted so far (optionally spoiled).
  typedef enum logic [1:0] {
    CrcAsIs,
    CrcLoFill,
    CrcHiFill,
    CrcHiSpoil
  } crc_fill_e;

  // One directed row. A pinned row carries its expected status; error results
  // always hold zero temperature and humidity, so the status says it all.
  typedef struct packed {
    logic [7:0]        data;
    logic              mark;
    crc_fill_e         fill;
    logic              pinned;
    sfcd_pkg::status_e pin_status;
  } row_t;

  localparam int NumRows = 26;
  localparam int PhaseItems = 350;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  sfcd_pkg::in_item_t  in_data   = '0;
  logic                in_stall;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sfcd_pkg::out_item_t out_data;

  // Idle and stall odds in percent, set per phase
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  int unsigned items_sent  = 0;
  int unsigned error_count = 0;

  // Decoder state mirrored from the frame rules
  logic [2:0]  frame_pos  = sfcd_pkg::IdxCode;
  logic [15:0] crc_acc    = sfcd_pkg::CrcInit;
  logic        code_wrong = 1'b0;
  logic [15:0] hum_word   = '0;
  logic [15:0] temp_word  = '0;
  logic [7:0]  crc_lo     = '0;

  // Decoded frames still owed by the block, oldest first
  sfcd_pkg::out_item_t frame_results_q[$];
  sfcd_pkg::out_item_t want_res;

  row_t directed_rows [NumRows];

  sensor_frame_check_decode_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest correct run of about 1400 items
  initial begin
    #5_000_000;
    $display("sensor_frame_check_decode_core test failed");
    $finish;
  end

  // Reflected CRC-16, one bit at a time: feed each data bit (LSB first) into
  // the feedback tap and fold the polynomial in when it is set.
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ sfcd_pkg::CrcPoly;
      end
    end
    return r;
  endfunction

  // Advance the mirrored decoder by one accepted byte; raise done with the
  // decoded frame when the byte closes a frame.
  function automatic void decode_byte(input sfcd_pkg::in_item_t it, output logic done,
                                      output sfcd_pkg::out_item_t res);
    logic [2:0]  pos;
    logic [15:0] mag;
    logic [15:0] rx_crc;
    pos  = it.frame_start ? sfcd_pkg::IdxCode : frame_pos;
    done = 1'b0;
    res  = '0;
    case (pos)
      sfcd_pkg::IdxCode: begin
        // restart the CRC on every first byte, marked or wrapped
        code_wrong = (it.rx_byte != sfcd_pkg::FuncCode);
        crc_acc    = crc16_fold(sfcd_pkg::CrcInit, it.rx_byte);
      end
      sfcd_pkg::IdxLen: begin
        crc_acc = crc16_fold(crc_acc, it.rx_byte);
      end
      sfcd_pkg::IdxHumHi: begin
        crc_acc        = crc16_fold(crc_acc, it.rx_byte);
        hum_word[15:8] = it.rx_byte;
      end
      sfcd_pkg::IdxHumLo: begin
        crc_acc       = crc16_fold(crc_acc, it.rx_byte);
        hum_word[7:0] = it.rx_byte;
      end
      sfcd_pkg::IdxTempHi: begin
        crc_acc         = crc16_fold(crc_acc, it.rx_byte);
        temp_word[15:8] = it.rx_byte;
      end
      sfcd_pkg::IdxTempLo: begin
        crc_acc        = crc16_fold(crc_acc, it.rx_byte);
        temp_word[7:0] = it.rx_byte;
      end
      sfcd_pkg::IdxCrcLo: begin
        crc_lo = it.rx_byte;
      end
      default: begin
        // CRC travels low byte first; a bad code wins over a bad CRC
        rx_crc = {it.rx_byte, crc_lo};
        done   = 1'b1;
        if (code_wrong) begin
          res.status = sfcd_pkg::StatusCodeBad;
        end else if (rx_crc != crc_acc) begin
          res.status = sfcd_pkg::StatusCrcBad;
        end else begin
          // sign-magnitude to two's complement; negative zero folds to zero
          mag = {temp_word[15:8] & sfcd_pkg::MagMask, temp_word[7:0]};
          res.status = sfcd_pkg::StatusOk;
          if ((temp_word[15:8] & sfcd_pkg::SignBit) != 8'h00) begin
            res.temperature_tenths = 16'(16'd0 - mag);
          end else begin
            res.temperature_tenths = mag;
          end
          res.humidity_tenths = hum_word;
        end
      end
    endcase
    frame_pos = pos + 3'd1;
  endfunction

  // Offer one byte, idling first at the phase's odds; hold it until taken,
  // then advance the mirrored decoder and queue any frame it closes.
  task automatic send_byte(input sfcd_pkg::in_item_t it, input logic pinned,
                           input sfcd_pkg::status_e pin_status);
    logic                done;
    sfcd_pkg::out_item_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
    decode_byte(it, done, res);
    if (done) begin
      if (pinned) begin
        res        = '0;
        res.status = pin_status;
      end
      frame_results_q.push_back(res);
    end
  endtask

  // Drop valid and hold off until every queued frame has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frame_results_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Field bytes lean toward the sign and range edges
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One well-formed frame with random content: mostly the right code and a
  // good CRC, sometimes a wrong code or a damaged CRC.
  task automatic send_frame(input logic force_mark);
    logic [7:0]         fb [8];
    logic [15:0]        crc;
    sfcd_pkg::in_item_t it;
    fb[0] = ($urandom_range(99) < 92) ? sfcd_pkg::FuncCode : 8'($urandom_range(255));
    for (int i = 1; i < 6; i++) begin
      fb[i] = pick_byte();
    end
    crc = sfcd_pkg::CrcInit;
    for (int i = 0; i < 6; i++) begin
      crc = crc16_fold(crc, fb[i]);
    end
    case ($urandom_range(9))
      0:       crc = crc ^ (16'd1 << $urandom_range(15));
      1:       crc = 16'($urandom_range(16'hFFFF));
      default: ;
    endcase
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      it.rx_byte     = fb[i];
      it.frame_start = (i == 0) && (force_mark || ($urandom_range(99) < 70));
      send_byte(it, 1'b0, sfcd_pkg::StatusOk);
    end
  endtask

  // A broken run of 1-7 random bytes, with stray marks now and then
  task automatic send_noise();
    sfcd_pkg::in_item_t it;
    int unsigned        n;
    n = $urandom_range(7, 1);
    for (int unsigned i = 0; i < n; i++) begin
      it.rx_byte     = 8'($urandom_range(255));
      it.frame_start = (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 10);
      send_byte(it, 1'b0, sfcd_pkg::StatusOk);
    end
  endtask

  // Stall the result side at the phase's odds
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare each taken result with the oldest queued frame
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (frame_results_q.size() == 0) begin
        $error("result with no frame pending: status %0d", out_data.status);
        error_count++;
      end else begin
        want_res = frame_results_q.pop_front();
        if (out_data.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_data.status);
          error_count++;
        end
        if (out_data.temperature_tenths !== want_res.temperature_tenths) begin
          $error("temperature_tenths: expected %0d, got %0d",
                 want_res.temperature_tenths, out_data.temperature_tenths);
          error_count++;
        end
        if (out_data.humidity_tenths !== want_res.humidity_tenths) begin
          $error("humidity_tenths: expected %0d, got %0d",
                 want_res.humidity_tenths, out_data.humidity_tenths);
          error_count++;
        end
      end
    end
  end

  initial begin
    row_t               r;
    sfcd_pkg::in_item_t it;
    logic               force_mark;
    int unsigned        target;

    directed_rows = '{
      // bad code with every bit high, CRC also wrong: code error must win
      '{8'hFF, 1'b1, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcAsIs, 1'b1, sfcd_pkg::StatusCodeBad},
      // partial frame, dropped by the mark that follows
      '{8'h03, 1'b1, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h05, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      // good frame, full humidity, negative zero temperature
      '{8'h03, 1'b1, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h80, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcLoFill, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcHiFill, 1'b0, sfcd_pkg::StatusOk},
      // back to back without a mark, top temperature, CRC spoiled
      '{8'h03, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h7F, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'hFF, 1'b0, CrcAsIs, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcLoFill, 1'b0, sfcd_pkg::StatusOk},
      '{8'h00, 1'b0, CrcHiSpoil, 1'b1, sfcd_pkg::StatusCrcBad}
    };

    // hold reset low, then release it on a clock edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, no idling; CRC bytes filled from the running CRC
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      it.frame_start = r.mark;
      case (r.fill)
        CrcLoFill:  it.rx_byte = crc_acc[7:0];
        CrcHiFill:  it.rx_byte = crc_acc[15:8];
        CrcHiSpoil: it.rx_byte = crc_acc[15:8] ^ 8'h80;
        default:    it.rx_byte = r.data;
      endcase
      send_byte(it, r.pinned, r.pin_status);
    end
    drain_results();

    // Random phases: free flow, sender gaps, receiver stalls, light both;
    // drain between phases so the sender sits out until every frame is back
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      target     = items_sent + PhaseItems;
      force_mark = 1'b1;
      while (items_sent < target) begin
        if ($urandom_range(99) < 8) begin
          send_noise();
          force_mark = 1'b1;
        end else begin
          send_frame(force_mark);
          force_mark = 1'b0;
        end
      end
      drain_results();
    end

    // allow a stray late result to show up before the verdict
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sensor_frame_check_decode_core test passed");
    end else begin
      $display("sensor_frame_check_decode_core test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sfcd_pkg.sv
src/sensor_frame_check_decode_core.sv
tb/tb.sv
